[rtl/core/voxel_downsample_2x2x2_top_assert.svh]
// ----------------------------------------------------------------------------
// voxel downsampler assertion macros
// concurrent assertion helpers, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef VOXEL_DOWNSAMPLE_2X2X2_TOP_ASSERT_SVH
`define VOXEL_DOWNSAMPLE_2X2X2_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define VDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// expression must never be true outside reset
`define VDS_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define VDS_ASSERT(lbl, clk, rstn, prop)
`define VDS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[rtl/core/vds_pkg.sv]
// ----------------------------------------------------------------------------
// vds_pkg
// shared constants and types of the 2x2x2 voxel downsampler
// ----------------------------------------------------------------------------
package vds_pkg;

  localparam int MaxFineDim  = 128;
  localparam int CondBits    = 16;
  localparam int NumCh       = 6;
  localparam int CondW       = 16;
  localparam int KindW       = 8;
  localparam int CfgW        = 8;
  localparam int CfgIdxW     = 2;
  localparam int CoarseDim   = (MaxFineDim + 1) / 2;
  localparam int CoarseCells = CoarseDim * CoarseDim;
  localparam int IdxW        = (CoarseCells > 1) ? $clog2(CoarseCells) : 1;
  localparam int PosW        = (MaxFineDim > 1) ? $clog2(MaxFineDim) : 1;
  localparam int SizeW       = $clog2(MaxFineDim + 1);
  localparam int SumW        = CondBits + 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegSizeX = 2'd0,
    RegSizeY = 2'd1,
    RegSizeZ = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                       solid;
    logic [NumCh-1:0][SumW-1:0] sum;
  } acc_t;

endpackage

[rtl/core/vds_vox_if.sv]
// ----------------------------------------------------------------------------
// vds_vox_if
// fine voxel channel: valid/ready handshake with six channels and type byte
// ----------------------------------------------------------------------------
interface vds_vox_if;
  logic                      valid;
  logic                      ready;
  logic [vds_pkg::CondW-1:0] cond_0;
  logic [vds_pkg::CondW-1:0] cond_1;
  logic [vds_pkg::CondW-1:0] cond_2;
  logic [vds_pkg::CondW-1:0] cond_3;
  logic [vds_pkg::CondW-1:0] cond_4;
  logic [vds_pkg::CondW-1:0] cond_5;
  logic [vds_pkg::KindW-1:0] voxel_kind;

  modport source (
    output valid, cond_0, cond_1, cond_2, cond_3, cond_4, cond_5, voxel_kind,
    input  ready
  );
  modport sink (
    input  valid, cond_0, cond_1, cond_2, cond_3, cond_4, cond_5, voxel_kind,
    output ready
  );
endinterface

[rtl/core/vds_cell_if.sv]
// ----------------------------------------------------------------------------
// vds_cell_if
// coarse cell channel: valid/ready handshake with averages and flags
// ----------------------------------------------------------------------------
interface vds_cell_if;
  logic                      valid;
  logic                      ready;
  logic [vds_pkg::CondW-1:0] avg_0;
  logic [vds_pkg::CondW-1:0] avg_1;
  logic [vds_pkg::CondW-1:0] avg_2;
  logic [vds_pkg::CondW-1:0] avg_3;
  logic [vds_pkg::CondW-1:0] avg_4;
  logic [vds_pkg::CondW-1:0] avg_5;
  logic                      coarse_solid;
  logic                      volume_end;

  modport source (
    output valid, avg_0, avg_1, avg_2, avg_3, avg_4, avg_5, coarse_solid, volume_end,
    input  ready
  );
  modport sink (
    input  valid, avg_0, avg_1, avg_2, avg_3, avg_4, avg_5, coarse_solid, volume_end,
    output ready
  );
endinterface

[rtl/core/voxel_downsample_2x2x2_top.sv]
// ----------------------------------------------------------------------------
// voxel_downsample_2x2x2_top
// streaming 2x2x2 box-filter downsampler over a coarse-plane accumulator ram
// ----------------------------------------------------------------------------
// a cell's last voxel enters stage one, then its result enters the output register
// throughput: one voxel beat per cycle, one read-modify-write of the ram per
//   voxel; the input stalls only while a finished cell waits behind a held result
// reset: position clears to zero and extents to 128; the accumulator ram is
//   not cleared, each cell's first voxel overwrites its entry
module voxel_downsample_2x2x2_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vds_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [vds_pkg::CfgW-1:0]    cfg_data_i,
  vds_vox_if.sink                     vox_i,
  vds_cell_if.source                  cell_o
);

`include "voxel_downsample_2x2x2_top_assert.svh"

  localparam int NumCh    = vds_pkg::NumCh;
  localparam int CondBits = vds_pkg::CondBits;
  localparam int SumW     = vds_pkg::SumW;
  localparam int PosW     = vds_pkg::PosW;
  localparam int SizeW    = vds_pkg::SizeW;
  localparam int IdxW     = vds_pkg::IdxW;
  localparam int CondW    = vds_pkg::CondW;

  // configuration and raster position
  logic [SizeW-1:0] size_x_q, size_y_q, size_z_q;
  logic [PosW-1:0]  pos_x_q, pos_y_q, pos_z_q;
  logic [PosW-1:0]  pos_x_d, pos_y_d, pos_z_d;
  logic [SizeW-1:0] cfg_size;
  logic             cfg_hit;

  // stage one: ram read data in flight
  logic                               s1_valid_q;
  logic [IdxW-1:0]                    s1_idx_q;
  logic [NumCh-1:0][CondBits-1:0]     s1_val_q;
  logic                               s1_solid_q, s1_first_q, s1_emit_q, s1_end_q;
  logic                               fwd_hit_q;
  vds_pkg::acc_t                      fwd_q;
  vds_pkg::acc_t                      mem_rdata_q;
  vds_pkg::acc_t                      acc_old, acc_new;
  logic                               s1_adv;

  // output register
  logic                               out_valid_q;
  logic [NumCh-1:0][CondW-1:0]        out_avg_q;
  logic                               out_solid_q, out_end_q;

  // accumulator ram
  vds_pkg::acc_t acc_mem [vds_pkg::CoarseCells];

  // accept-side decode
  logic                           accept;
  logic                           end_x, end_y, end_z;
  logic                           last_x, last_y, last_z;
  logic                           in_first;
  logic [IdxW-1:0]                in_idx;
  logic [NumCh-1:0][CondBits-1:0] in_val;

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_size = SizeW'(1);
    end else if (int'(cfg_data_i) > vds_pkg::MaxFineDim) begin
      cfg_size = SizeW'(vds_pkg::MaxFineDim);
    end else begin
      cfg_size = SizeW'(cfg_data_i);
    end
  end

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vds_pkg::RegSizeX,
        vds_pkg::RegSizeY,
        vds_pkg::RegSizeZ: cfg_hit = 1'b1;
        default:           cfg_hit = 1'b0;
      endcase
    end
  end

  assign s1_adv       = s1_valid_q && (!s1_emit_q || !out_valid_q || cell_o.ready);
  assign vox_i.ready  = !s1_valid_q || s1_adv;
  assign accept       = vox_i.valid && vox_i.ready;

  assign end_x  = (SizeW'(pos_x_q) + SizeW'(1)) == size_x_q;
  assign end_y  = (SizeW'(pos_y_q) + SizeW'(1)) == size_y_q;
  assign end_z  = (SizeW'(pos_z_q) + SizeW'(1)) == size_z_q;
  assign last_x = pos_x_q[0] || end_x;
  assign last_y = pos_y_q[0] || end_y;
  assign last_z = pos_z_q[0] || end_z;
  assign in_first = !pos_x_q[0] && !pos_y_q[0] && !pos_z_q[0];
  assign in_idx = IdxW'(IdxW'(pos_y_q >> 1) * IdxW'(vds_pkg::CoarseDim))
                + IdxW'(pos_x_q >> 1);

  always_comb begin
    in_val[0] = CondBits'(vox_i.cond_0);
    in_val[1] = CondBits'(vox_i.cond_1);
    in_val[2] = CondBits'(vox_i.cond_2);
    in_val[3] = CondBits'(vox_i.cond_3);
    in_val[4] = CondBits'(vox_i.cond_4);
    in_val[5] = CondBits'(vox_i.cond_5);
  end

  // raster advance, x fastest
  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (end_x) begin
      pos_x_d = '0;
      if (end_y) begin
        pos_y_d = '0;
        pos_z_d = end_z ? '0 : pos_z_q + PosW'(1);
      end else begin
        pos_y_d = pos_y_q + PosW'(1);
      end
    end else begin
      pos_x_d = pos_x_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SizeW'(vds_pkg::MaxFineDim);
      size_y_q <= SizeW'(vds_pkg::MaxFineDim);
      size_z_q <= SizeW'(vds_pkg::MaxFineDim);
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      pos_z_q  <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_idx_i)
        vds_pkg::RegSizeX: size_x_q <= cfg_size;
        vds_pkg::RegSizeY: size_y_q <= cfg_size;
        vds_pkg::RegSizeZ: size_z_q <= cfg_size;
        default: ;
      endcase
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (accept) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
    end
  end

  // read-modify-write, forwarding the entry written on the accept edge
  always_comb begin
    acc_old = fwd_hit_q ? fwd_q : mem_rdata_q;
    for (int c = 0; c < NumCh; c++) begin
      acc_new.sum[c] = s1_first_q ? SumW'(s1_val_q[c])
                                  : acc_old.sum[c] + SumW'(s1_val_q[c]);
    end
    acc_new.solid = s1_first_q ? s1_solid_q : (acc_old.solid | s1_solid_q);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_rdata_q <= acc_mem[in_idx];
    end
    if (s1_adv) begin
      acc_mem[s1_idx_q] <= acc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= s1_valid_q && (s1_idx_q == in_idx);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
        fwd_hit_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q   <= in_idx;
      s1_val_q   <= in_val;
      s1_solid_q <= vox_i.voxel_kind != '0;
      s1_first_q <= in_first;
      s1_emit_q  <= last_x && last_y && last_z;
      s1_end_q   <= end_x && end_y && end_z;
      fwd_q      <= acc_new;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (cell_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      for (int c = 0; c < NumCh; c++) begin
        out_avg_q[c] <= CondW'(acc_new.sum[c] >> 3);
      end
      out_solid_q <= acc_new.solid;
      out_end_q   <= s1_end_q;
    end
  end

  assign cell_o.valid        = out_valid_q;
  assign cell_o.avg_0        = out_avg_q[0];
  assign cell_o.avg_1        = out_avg_q[1];
  assign cell_o.avg_2        = out_avg_q[2];
  assign cell_o.avg_3        = out_avg_q[3];
  assign cell_o.avg_4        = out_avg_q[4];
  assign cell_o.avg_5        = out_avg_q[5];
  assign cell_o.coarse_solid = out_solid_q;
  assign cell_o.volume_end   = out_end_q;

  // a voxel beat is taken only when stage one drains or is empty
  `VDS_ASSERT(a_accept_free, clk_i, rst_ni, accept |-> (!s1_valid_q || s1_adv))
  // forwarded entry only exists behind a live stage one
  `VDS_ASSERT(a_fwd_live, clk_i, rst_ni, fwd_hit_q |-> s1_valid_q)
  // a finished cell never overwrites a result still waiting
  `VDS_ASSERT_NEVER(a_no_overrun, clk_i, rst_ni,
                    s1_adv && s1_emit_q && out_valid_q && !cell_o.ready)
  // the volume's last voxel always closes a cell and rewinds the raster
  `VDS_ASSERT(a_end_wrap, clk_i, rst_ni,
              (accept && !cfg_hit && end_x && end_y && end_z)
              |=> (pos_x_q == '0 && pos_y_q == '0 && pos_z_q == '0))

endmodule
